### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(LBL, CLK, RST_N, ANT, CON) \
	LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANT) |-> (CON)) \
		else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(LBL, CLK, RST_N, ANT, CON) \
	LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANT) |=> (CON)) \
		else $error("assertion failed: next-cycle implication");

// Condition must never be true
`define ASSERT_NEVER(LBL, CLK, RST_N, COND) \
	LBL: assert property (@(posedge CLK) disable iff (!RST_N) !(COND)) \
		else $error("assertion failed: forbidden condition");

`endif

### sv/asvf_pkg.sv
// ---------------------------------------------------------------------------
// asvf_pkg
// Constants, types and helpers shared by the afterimage streak filter.
// ---------------------------------------------------------------------------
package asvf_pkg;

	// Frame store geometry
	localparam int MAX_FRAME_PIXELS = 131072;
	localparam int POS_W            = $clog2(MAX_FRAME_PIXELS);
	localparam int PLANE_COUNT      = 32;
	localparam int PLANE_W          = $clog2(PLANE_COUNT);
	localparam int PLANE_GROUP      = 4;
	localparam int GROUP_W          = $clog2(PLANE_GROUP);
	localparam int BANKS            = PLANE_COUNT / PLANE_GROUP;
	localparam int BANK_W           = $clog2(BANKS);
	localparam int ADDR_W           = GROUP_W + POS_W;

	// Pixel lanes: four channels, top five bits of each kept
	localparam int LANES      = 4;
	localparam int CHAN_W     = 8;
	localparam int KEEP_SHIFT = 3;
	localparam int LANE_W     = CHAN_W - KEEP_SHIFT;
	localparam int WORD_W     = LANES * LANE_W;
	localparam int PIXEL_W    = LANES * CHAN_W;

	// Configuration
	localparam int FRAME_W     = 18;
	localparam int FRAME_RESET = 76800;

	typedef logic [WORD_W-1:0]             word_t;
	typedef logic [BANKS-1:0][WORD_W-1:0]  bank_data_t;
	typedef logic [LANES-1:0][CHAN_W-1:0]  lane_sum_t;

	// Pixel handed from the control stage to the summing stage
	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
		word_t             value;
		logic              last;
	} issue_t;

	// Memory request shared by all eight banks
	typedef struct packed {
		logic              clear;
		logic              wr;
		logic              rd;
		logic [BANK_W-1:0] bank;
		logic [ADDR_W-1:0] addr;
		word_t             wdata;
	} mem_req_t;

	// Keep the top five bits of every channel, packed into one store word
	function automatic word_t pack_pixel(input logic [PIXEL_W-1:0] pix);
		word_t w;
		w = '0;
		for (int c = 0; c < LANES; c++) begin
			w[c*LANE_W +: LANE_W] = pix[c*CHAN_W + KEEP_SHIFT +: LANE_W];
		end
		return w;
	endfunction

endpackage

### sv/asvf_ram.sv
// ---------------------------------------------------------------------------
// asvf_ram
// Single-port synchronous RAM, registered read, read-before-write.
// ---------------------------------------------------------------------------
module asvf_ram #(
	parameter int WIDTH  = 20,
	parameter int ADDR_W = 19
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/asvf_ctrl.sv
// ---------------------------------------------------------------------------
// asvf_ctrl
// Frame size register, position and plane counters, store clearing sweep
// and input handshake.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module asvf_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [asvf_pkg::FRAME_W-1:0]      cfg_wr_data,
	input  logic                              pixel_in_valid,
	output logic                              pixel_in_ready,
	input  logic [asvf_pkg::PIXEL_W-1:0]      pixel_in,
	input  logic                              s1_free,
	output asvf_pkg::issue_t                  issue,
	output asvf_pkg::mem_req_t                mem_req
);

	logic [asvf_pkg::FRAME_W-1:0] frame_q;
	logic [asvf_pkg::POS_W-1:0]   pos_q;
	logic [asvf_pkg::PLANE_W-1:0] plane_q;
	logic                         clearing_q;
	logic [asvf_pkg::ADDR_W-1:0]  clr_cnt_q;

	logic [asvf_pkg::FRAME_W-1:0] size_eff;
	logic [asvf_pkg::FRAME_W-1:0] pos_inc;
	logic                         last;
	logic                         accept;
	asvf_pkg::word_t              value;

	// Frame size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= asvf_pkg::FRAME_W'(asvf_pkg::FRAME_RESET);
		end else if (cfg_wr_en) begin
			frame_q <= cfg_wr_data;
		end
	end

	// Effective size: zero acts as one, oversize clamps to the store depth
	always_comb begin
		priority if (frame_q == '0) begin
			size_eff = asvf_pkg::FRAME_W'(1);
		end else if (frame_q > asvf_pkg::FRAME_W'(asvf_pkg::MAX_FRAME_PIXELS)) begin
			size_eff = asvf_pkg::FRAME_W'(asvf_pkg::MAX_FRAME_PIXELS);
		end else begin
			size_eff = frame_q;
		end
	end

	assign pos_inc        = {1'b0, pos_q} + asvf_pkg::FRAME_W'(1);
	assign last           = (pos_inc >= size_eff);
	assign pixel_in_ready = !clearing_q && s1_free;
	assign accept         = pixel_in_valid && pixel_in_ready;
	assign value          = asvf_pkg::pack_pixel(pixel_in);

	// Clearing sweep: one row of all banks per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + asvf_pkg::ADDR_W'(1);
			if (clr_cnt_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Position and plane counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			plane_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q   <= '0;
				plane_q <= plane_q + asvf_pkg::PLANE_W'(1);
			end else begin
				pos_q <= pos_inc[asvf_pkg::POS_W-1:0];
			end
		end
	end

	// Bank = plane / 4, row = (plane mod 4, position)
	always_comb begin
		mem_req.clear = clearing_q;
		mem_req.wr    = accept;
		mem_req.rd    = accept;
		mem_req.bank  = plane_q[asvf_pkg::PLANE_W-1:asvf_pkg::GROUP_W];
		mem_req.addr  = clearing_q ? clr_cnt_q
			: {plane_q[asvf_pkg::GROUP_W-1:0], pos_q};
		mem_req.wdata = clearing_q ? '0 : value;

		issue.valid = accept;
		issue.bank  = plane_q[asvf_pkg::PLANE_W-1:asvf_pkg::GROUP_W];
		issue.value = value;
		issue.last  = last;
	end

	`ASSERT_NEVER(a_no_accept_in_clear, clk, arst_n, accept && clearing_q)
	`ASSERT_NEXT(a_last_wraps_pos, clk, arst_n, accept && last, pos_q == '0)
	`ASSERT_NEXT(a_last_steps_plane, clk, arst_n, accept && last,
		plane_q == $past(plane_q) + asvf_pkg::PLANE_W'(1))

endmodule

### sv/asvf_sum.sv
// ---------------------------------------------------------------------------
// asvf_sum
// Read-data stage and output register: merges the freshly written plane
// with the seven planes read back and adds them byte by byte.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module asvf_sum (
	input  logic                   clk,
	input  logic                   arst_n,
	input  asvf_pkg::issue_t       issue,
	input  asvf_pkg::bank_data_t   rdata,
	output logic                   s1_free,
	input  logic                   out_ready,
	output logic                   out_valid,
	output asvf_pkg::lane_sum_t    out_sum,
	output logic                   out_last
);

	logic                          valid_s1;
	logic [asvf_pkg::BANK_W-1:0]   bank_s1;
	asvf_pkg::word_t               value_s1;
	logic                          last_s1;

	logic                          out_valid_q;
	asvf_pkg::lane_sum_t           out_sum_q;
	logic                          out_last_q;

	logic                          out_free;
	logic                          adv_s1;
	asvf_pkg::bank_data_t          sel;
	asvf_pkg::lane_sum_t           sum;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || out_free;

	// Stage 1 control: matches the registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue.valid) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.valid) begin
			bank_s1  <= issue.bank;
			value_s1 <= issue.value;
			last_s1  <= issue.last;
		end
	end

	// Own bank reads the old word in the write cycle: take the new value
	always_comb begin
		for (int b = 0; b < asvf_pkg::BANKS; b++) begin
			sel[b] = (bank_s1 == asvf_pkg::BANK_W'(b)) ? value_s1 : rdata[b];
		end
		for (int c = 0; c < asvf_pkg::LANES; c++) begin
			sum[c] = '0;
			for (int b = 0; b < asvf_pkg::BANKS; b++) begin
				sum[c] = sum[c]
					+ asvf_pkg::CHAN_W'(sel[b][c*asvf_pkg::LANE_W +: asvf_pkg::LANE_W]);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_sum_q  <= sum;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;
	assign out_last  = out_last_q;

	`ASSERT_NEXT(a_issue_fills_s1, clk, arst_n, issue.valid, valid_s1)
	`ASSERT_NEVER(a_no_issue_when_blocked, clk, arst_n, issue.valid && !s1_free)
	`ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, valid_s1 && !out_free,
		valid_s1 && $stable(value_s1) && $stable(rdata))

endmodule

### sv/afterimage_streak_video_filter.sv
// ---------------------------------------------------------------------------
// afterimage_streak_video_filter
// Afterimage streak effect over a 32-plane frame store.
// ---------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per pixel, registered in
// the read-data stage and then the output register, sustaining one transfer
// per cycle while the output is taken. The frame store is eight single-port
// RAM banks (bank = plane / 4, each bank holding four planes at rows plane
// mod 4), so each pixel costs one read of every bank and one write of its own
// bank in the same cycle; that single memory access per pixel sets the rate.
// After reset the block sweeps zeros through all 524288 rows of every bank,
// one row per cycle, with pixel_in_ready low; frame size writes are taken
// during the sweep. A frame size write applies from the next pixel; if the
// position has already reached the new frame end, that pixel closes the
// frame. The store is never cleared by a size change.
// ---------------------------------------------------------------------------
module afterimage_streak_video_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [asvf_pkg::FRAME_W-1:0]      cfg_wr_data,
	input  logic                              pixel_in_valid,
	output logic                              pixel_in_ready,
	input  logic [asvf_pkg::PIXEL_W-1:0]      pixel_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [asvf_pkg::CHAN_W-1:0]       out_byte0,
	output logic [asvf_pkg::CHAN_W-1:0]       out_byte1,
	output logic [asvf_pkg::CHAN_W-1:0]       out_byte2,
	output logic [asvf_pkg::CHAN_W-1:0]       out_byte3,
	output logic                              frame_last
);

	asvf_pkg::issue_t     issue;
	asvf_pkg::mem_req_t   mem_req;
	asvf_pkg::bank_data_t rdata;
	asvf_pkg::lane_sum_t  out_sum;
	logic                 s1_free;

	// Counters, clearing sweep and handshake
	asvf_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.pixel_in_valid (pixel_in_valid),
		.pixel_in_ready (pixel_in_ready),
		.pixel_in       (pixel_in),
		.s1_free        (s1_free),
		.issue          (issue),
		.mem_req        (mem_req)
	);

	// Plane banks: all read at the shared row, own bank written
	for (genvar b = 0; b < asvf_pkg::BANKS; b++) begin : g_bank
		logic we;

		assign we = mem_req.clear
			|| (mem_req.wr && (mem_req.bank == asvf_pkg::BANK_W'(b)));

		asvf_ram #(
			.WIDTH  (asvf_pkg::WORD_W),
			.ADDR_W (asvf_pkg::ADDR_W)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.re    (mem_req.rd),
			.addr  (mem_req.addr),
			.wdata (mem_req.wdata),
			.rdata (rdata[b])
		);
	end

	// Byte sums and output register
	asvf_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.rdata     (rdata),
		.s1_free   (s1_free),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_sum   (out_sum),
		.out_last  (frame_last)
	);

	assign out_byte0 = out_sum[0];
	assign out_byte1 = out_sum[1];
	assign out_byte2 = out_sum[2];
	assign out_byte3 = out_sum[3];

endmodule
